/* rtl/core/bcc_pkg.sv */
package bcc_pkg;

    // Counter storage geometry.
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_COUNT   = 64;
    localparam int IDX_W       = $clog2(BIN_COUNT);
    localparam int OUT_W       = 32;
    localparam int ADDR_W      = 4;

    // Command codes of an input word.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Upper two bits of a symbol that lies in the binned range.
    localparam logic [1:0] SYM_RANGE_TAG = 2'b01;

    // Register index of the alphabet mask.
    localparam logic REG_ALPHABET_MASK = 1'b0;

    // Bin indexes of the characters that feed the GC sums and the presence flags.
    localparam logic [IDX_W-1:0] BIN_UPPER_A = IDX_W'(7'h41);
    localparam logic [IDX_W-1:0] BIN_UPPER_C = IDX_W'(7'h43);
    localparam logic [IDX_W-1:0] BIN_UPPER_G = IDX_W'(7'h47);
    localparam logic [IDX_W-1:0] BIN_UPPER_T = IDX_W'(7'h54);
    localparam logic [IDX_W-1:0] BIN_LOWER_C = IDX_W'(7'h63);
    localparam logic [IDX_W-1:0] BIN_LOWER_G = IDX_W'(7'h67);

    // ASCII codes of the IUPAC letters.
    localparam logic [6:0] CHAR_A = 7'h41;
    localparam logic [6:0] CHAR_B = 7'h42;
    localparam logic [6:0] CHAR_C = 7'h43;
    localparam logic [6:0] CHAR_D = 7'h44;
    localparam logic [6:0] CHAR_G = 7'h47;
    localparam logic [6:0] CHAR_H = 7'h48;
    localparam logic [6:0] CHAR_K = 7'h4B;
    localparam logic [6:0] CHAR_M = 7'h4D;
    localparam logic [6:0] CHAR_N = 7'h4E;
    localparam logic [6:0] CHAR_R = 7'h52;
    localparam logic [6:0] CHAR_S = 7'h53;
    localparam logic [6:0] CHAR_T = 7'h54;
    localparam logic [6:0] CHAR_V = 7'h56;
    localparam logic [6:0] CHAR_W = 7'h57;
    localparam logic [6:0] CHAR_Y = 7'h59;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  symbol;
        logic [31:0] weight;
    } item_t;

    typedef struct packed {
        logic [31:0]        symbol_count;
        logic [31:0]        total_count;
        logic [31:0]        gc_count;
        logic signed [31:0] gc_difference;
        logic [6:0]         degenerate_base;
        logic               symbol_ignored;
    } result_t;

    // Bin write request from the update logic to the bin store.
    typedef struct packed {
        logic                   en;
        logic                   clear;
        logic [IDX_W-1:0]       idx;
        logic [COUNT_WIDTH-1:0] data;
    } bin_wr_t;

    // IUPAC code for a presence set: bit 0 A, bit 1 C, bit 2 G, bit 3 T.
    function automatic logic [6:0] iupac_code(input logic [3:0] pres);
        logic [6:0] code;
        unique case (pres)
            4'h0:    code = CHAR_N;
            4'h1:    code = CHAR_A;
            4'h2:    code = CHAR_C;
            4'h3:    code = CHAR_M;
            4'h4:    code = CHAR_G;
            4'h5:    code = CHAR_R;
            4'h6:    code = CHAR_S;
            4'h7:    code = CHAR_V;
            4'h8:    code = CHAR_T;
            4'h9:    code = CHAR_W;
            4'hA:    code = CHAR_Y;
            4'hB:    code = CHAR_H;
            4'hC:    code = CHAR_K;
            4'hD:    code = CHAR_D;
            4'hE:    code = CHAR_B;
            default: code = CHAR_N;
        endcase
        return code;
    endfunction

endpackage

/* rtl/core/bcc_cfg.sv */
module bcc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    output logic [bcc_pkg::BIN_COUNT-1:0] alphabet_mask
);
    import bcc_pkg::*;

    logic [BIN_COUNT-1:0] mask_reg;
    logic                 hit;

    // Registers are 64 bits wide and sit on 8-byte boundaries.
    assign hit    = (paddr[ADDR_W-1] == REG_ALPHABET_MASK);
    assign pready = 1'b1;

    // Register write on the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (psel && penable && pwrite && hit)
        begin
            mask_reg <= pwdata[BIN_COUNT-1:0];
        end
    end

    // Read back.
    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata[BIN_COUNT-1:0] = mask_reg;
        end
    end

    assign alphabet_mask = mask_reg;

endmodule

/* rtl/core/bcc_bin_store.sv */
module bcc_bin_store (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [bcc_pkg::IDX_W-1:0]         rd_idx,
    input  bcc_pkg::bin_wr_t                  wr,
    output logic [bcc_pkg::COUNT_WIDTH-1:0]   old_count
);
    import bcc_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [BIN_COUNT-1:0]   valid_reg;
    logic                   vbit_reg;
    logic                   fwd_sel_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    // Bin memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_idx];
            fwd_data_reg <= wr.clear ? '0 : wr.data;
        end
    end

    // A bin that was never written since the last clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            vbit_reg    <= 1'b0;
            fwd_sel_reg <= 1'b0;
        end
        else
        begin
            if (wr.clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            // A write or clear in the same cycle as the read is forwarded.
            if (rd_en)
            begin
                vbit_reg    <= valid_reg[rd_idx];
                fwd_sel_reg <= wr.clear || (wr.en && (wr.idx == rd_idx));
            end
        end
    end

    assign old_count = fwd_sel_reg ? fwd_data_reg : (vbit_reg ? rd_data_reg : '0);

endmodule

/* rtl/core/bcc_update.sv */
module bcc_update (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  bcc_pkg::item_t                    word,
    input  logic [bcc_pkg::COUNT_WIDTH-1:0]   old_count,
    input  logic [bcc_pkg::BIN_COUNT-1:0]     alphabet_mask,
    output bcc_pkg::bin_wr_t                  wr,
    output bcc_pkg::result_t                  result_word
);
    import bcc_pkg::*;

    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [COUNT_WIDTH-1:0] gc_reg, gc_next;
    logic [OUT_W-1:0]       diff_reg, diff_next;
    logic [3:0]             pres_reg, pres_next;
    result_t                out_reg, out_next;
    logic [IDX_W-1:0]       idx;
    logic                   in_range;
    logic                   is_clear;
    logic                   do_add;
    logic                   cnt_nz;
    logic [COUNT_WIDTH-1:0] new_count;

    assign idx       = word.symbol[IDX_W-1:0];
    assign in_range  = (word.symbol[7:IDX_W] == SYM_RANGE_TAG);
    assign is_clear  = (word.cmd == CMD_CLEAR);
    assign do_add    = (word.cmd == CMD_ADD) && in_range;
    assign new_count = old_count + COUNT_WIDTH'(word.weight);
    assign cnt_nz    = (new_count != '0);

    // Write request back to the bin store.
    always_comb
    begin
        wr.en    = fire && do_add;
        wr.clear = fire && is_clear;
        wr.idx   = idx;
        wr.data  = new_count;
    end

    // Running sums, the G minus C difference and the presence flags.
    always_comb
    begin
        total_next = total_reg;
        gc_next    = gc_reg;
        diff_next  = diff_reg;
        pres_next  = pres_reg;
        if (is_clear)
        begin
            total_next = '0;
            gc_next    = '0;
            diff_next  = '0;
            pres_next  = '0;
        end
        else if (do_add)
        begin
            if (alphabet_mask[idx])
            begin
                total_next = total_reg + COUNT_WIDTH'(word.weight);
            end
            if ((idx == BIN_UPPER_G) || (idx == BIN_LOWER_G))
            begin
                gc_next   = gc_reg + COUNT_WIDTH'(word.weight);
                diff_next = diff_reg + OUT_W'(word.weight);
            end
            if ((idx == BIN_UPPER_C) || (idx == BIN_LOWER_C))
            begin
                gc_next   = gc_reg + COUNT_WIDTH'(word.weight);
                diff_next = diff_reg - OUT_W'(word.weight);
            end
            if (idx == BIN_UPPER_A)
            begin
                pres_next[0] = cnt_nz;
            end
            if (idx == BIN_UPPER_C)
            begin
                pres_next[1] = cnt_nz;
            end
            if (idx == BIN_UPPER_G)
            begin
                pres_next[2] = cnt_nz;
            end
            if (idx == BIN_UPPER_T)
            begin
                pres_next[3] = cnt_nz;
            end
        end
    end

    // Result word for this item.
    always_comb
    begin
        out_next.symbol_count    = do_add ? OUT_W'(new_count) : '0;
        out_next.total_count     = OUT_W'(total_next);
        out_next.gc_count        = OUT_W'(gc_next);
        out_next.gc_difference   = diff_next;
        out_next.degenerate_base = iupac_code(pres_next);
        out_next.symbol_ignored  = !is_clear && !in_range;
    end

    // Accumulator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            gc_reg    <= '0;
            diff_reg  <= '0;
            pres_reg  <= '0;
        end
        else if (fire)
        begin
            total_reg <= total_next;
            gc_reg    <= gc_next;
            diff_reg  <= diff_next;
            pres_reg  <= pres_next;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    assign result_word = out_reg;

endmodule

/* rtl/core/dna_base_composition_counter_top.sv */
// Base composition counter. Each input word either adds its weight to the
// counter bin of one character code from 64 to 127 or clears every bin and
// running sum; each word produces one result word with the updated bin count,
// the total over the alphabet mask, the GC count, the signed G minus C
// difference and the IUPAC code for the uppercase bases present. Symbols
// outside 64 to 127 are flagged and change nothing. A new word is accepted
// every cycle while results are taken; the bin memory is read as a word
// enters the read stage, and as it leaves that stage the update logic
// writes the bin and loads the output register. A stalled result holds
// the word in the read stage and stops the input. The alphabet total uses the
// mask in force when each weight was added, so clear the counts after
// changing the mask. The mask is a 64-bit register at byte address 0 of the
// configuration port.
module dna_base_composition_counter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  bcc_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output bcc_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcc_pkg::ADDR_W-1:0]    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    import bcc_pkg::*;

    logic                   s1_valid_reg;
    item_t                  s1_word_reg;
    logic                   out_valid_reg;
    logic                   advance;
    logic                   load;
    logic                   fire;
    logic [BIN_COUNT-1:0]   alphabet_mask;
    logic [COUNT_WIDTH-1:0] old_count;
    bin_wr_t                wr;

    // Pipeline control: the read stage moves on whenever the output frees up.
    assign advance      = !out_valid_reg || result_ready;
    assign item_ready   = !s1_valid_reg || advance;
    assign load         = item_valid && item_ready;
    assign fire         = s1_valid_reg && advance;
    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Read stage word register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_word_reg <= item;
        end
    end

    bcc_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .alphabet_mask (alphabet_mask)
    );

    bcc_bin_store u_bins (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (load),
        .rd_idx    (item.symbol[IDX_W-1:0]),
        .wr        (wr),
        .old_count (old_count)
    );

    bcc_update u_update (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .word          (s1_word_reg),
        .old_count     (old_count),
        .alphabet_mask (alphabet_mask),
        .wr            (wr),
        .result_word   (result)
    );

endmodule

/* sim/tb_dna_base_composition_counter_top.sv */
module tb_dna_base_composition_counter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bcc_pkg::*;

    // Cycles without any accepted word before the run is declared hung.
    localparam int STALL_LIMIT = 2000;

    // Register byte addresses: the mask is index 0, index 1 holds nothing.
    localparam logic [ADDR_W-1:0] ADDR_MASK  = ADDR_W'(8 * REG_ALPHABET_MASK);
    localparam int                SPARE_REG  = 1;
    localparam logic [ADDR_W-1:0] ADDR_SPARE = ADDR_W'(8 * SPARE_REG);

    // IUPAC letter for each presence set: bit 0 A, bit 1 C, bit 2 G, bit 3 T.
    localparam logic [6:0] IUPAC_LETTER [16] = '{
        CHAR_N, CHAR_A, CHAR_C, CHAR_M, CHAR_G, CHAR_R, CHAR_S, CHAR_V,
        CHAR_T, CHAR_W, CHAR_Y, CHAR_H, CHAR_K, CHAR_D, CHAR_B, CHAR_N
    };

    // Nucleotide letters that most random words use.
    localparam logic [7:0] BASE_LETTER [8] = '{
        8'h41, 8'h43, 8'h47, 8'h54, 8'h61, 8'h63, 8'h67, 8'h74
    };

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    item_t            word_in      = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    result_t          word_out;
    logic             psel         = 1'b0;
    logic             penable      = 1'b0;
    logic             pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [63:0]      pwdata       = '0;
    logic [63:0]      prdata;
    logic             pready;

    // Words waiting to be sent and results still owed by the block.
    item_t   pending_words[$];
    result_t owed_results[$];

    // Shadow of the counter state and the mask register.
    logic [31:0] bin_tally [64];
    logic [31:0] total_tally = '0;
    logic [31:0] gc_tally    = '0;
    logic [63:0] mask_copy   = '0;

    int  errors      = 0;
    int  idle_cycles = 0;
    bit  idle_on     = 1'b0;
    int  send_gap    = 0;
    int  stall_left  = 0;

    dna_base_composition_counter_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (word_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (word_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 clk = ~clk;

    // Apply one word to the shadow counters and return the result it causes.
    function automatic result_t tally_word(input item_t w);
        result_t    r;
        logic [5:0] slot;
        logic [3:0] seen;
        r    = '0;
        slot = w.symbol[5:0];
        if (w.cmd == CMD_CLEAR)
        begin
            foreach (bin_tally[k])
                bin_tally[k] = '0;
            total_tally = '0;
            gc_tally    = '0;
        end
        else if (w.symbol[7:6] != SYM_RANGE_TAG)
        begin
            r.symbol_ignored = 1'b1;
        end
        else
        begin
            bin_tally[slot] = bin_tally[slot] + w.weight;
            r.symbol_count  = bin_tally[slot];
            if (mask_copy[slot])
                total_tally = total_tally + w.weight;
            if (slot == BIN_UPPER_G || slot == BIN_UPPER_C ||
                slot == BIN_LOWER_G || slot == BIN_LOWER_C)
                gc_tally = gc_tally + w.weight;
        end
        r.total_count   = total_tally;
        r.gc_count      = gc_tally;
        r.gc_difference = (bin_tally[BIN_UPPER_G] + bin_tally[BIN_LOWER_G])
                        - (bin_tally[BIN_UPPER_C] + bin_tally[BIN_LOWER_C]);
        seen = {bin_tally[BIN_UPPER_T] != 0, bin_tally[BIN_UPPER_G] != 0,
                bin_tally[BIN_UPPER_C] != 0, bin_tally[BIN_UPPER_A] != 0};
        r.degenerate_base = IUPAC_LETTER[seen];
        return r;
    endfunction

    // Random word: mostly nucleotide adds, some other letters, some
    // out-of-range symbols and the occasional clear.
    function automatic item_t random_word();
        item_t w;
        int    pick;
        pick     = $urandom_range(0, 99);
        w.cmd    = CMD_ADD;
        w.symbol = 8'($urandom_range(64, 127));
        case ($urandom_range(0, 3))
            0:       w.weight = 32'($urandom_range(0, 15));
            1:       w.weight = 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
            default: w.weight = $urandom;
        endcase
        if (pick < 4)
        begin
            w.cmd    = CMD_CLEAR;
            w.symbol = 8'($urandom_range(0, 255));
        end
        else if (pick < 14)
            w.symbol = $urandom_range(0, 1) ? 8'($urandom_range(0, 63))
                                            : 8'($urandom_range(128, 255));
        else if (pick < 75)
            w.symbol = BASE_LETTER[$urandom_range(0, 7)];
        return w;
    endfunction

    task automatic queue_word(input logic cmd, input logic [7:0] sym, input logic [31:0] wt);
        item_t w;
        w.cmd    = cmd;
        w.symbol = sym;
        w.weight = wt;
        pending_words.push_back(w);
    endtask

    // Block until every queued word is sent and every result has come back.
    task automatic wait_drained();
        while (pending_words.size() != 0 || item_valid || owed_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [63:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_MASK)
            mask_copy = data;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Read the mask back and compare it with the shadow copy.
    task automatic mask_readback();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MASK;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== mask_copy)
        begin
            $display("%0t: mask readback expected %h actual %h", $time, mask_copy, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input int count, input bit with_idle);
        idle_on = with_idle;
        repeat (count)
            pending_words.push_back(random_word());
        wait_drained();
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Sender: holds each word until it is taken, with random gap bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_ready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pending_words.size() != 0 && idle_on && $urandom_range(0, 4) == 0)
            begin
                send_gap = $urandom_range(1, 6) - 1;
                item_valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                word_in    <= pending_words.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver: ready with random stall bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(1, 6) - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // Predict on each accepted input word, check each accepted result word.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (item_valid && item_ready)
                owed_results.push_back(tally_word(word_in));
            if (result_valid && result_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %h", $time, word_out);
                    errors++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("symbol_count", want.symbol_count, word_out.symbol_count);
                    check_field("total_count", want.total_count, word_out.total_count);
                    check_field("gc_count", want.gc_count, word_out.gc_count);
                    check_field("gc_difference", want.gc_difference, word_out.gc_difference);
                    check_field("degenerate_base", 32'(want.degenerate_base),
                                32'(word_out.degenerate_base));
                    check_field("symbol_ignored", 32'(want.symbol_ignored),
                                32'(word_out.symbol_ignored));
                end
            end
        end
    end

    // Watchdog on cycles with no word accepted on either side.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("dna_base_composition_counter_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] nucleotide_mask;
        foreach (bin_tally[k])
            bin_tally[k] = '0;
        nucleotide_mask = (64'd1 << BIN_UPPER_A) | (64'd1 << BIN_UPPER_C)
                        | (64'd1 << BIN_UPPER_G) | (64'd1 << BIN_UPPER_T);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Mask comes out of reset as zero.
        mask_readback();
        reg_write(ADDR_MASK, nucleotide_mask);
        mask_readback();

        // Directed words: range edges, weight extremes, wrap, clear, IUPAC codes.
        idle_on = 1'b0;
        queue_word(CMD_ADD, 8'h41, 32'd1);
        queue_word(CMD_ADD, 8'h43, 32'hFFFF_FFFF);
        queue_word(CMD_ADD, 8'h43, 32'd2);
        queue_word(CMD_ADD, 8'h47, 32'h8000_0000);
        queue_word(CMD_ADD, 8'h54, 32'd0);
        queue_word(CMD_ADD, 8'h54, 32'd5);
        queue_word(CMD_ADD, 8'h67, 32'h7FFF_FFFF);
        queue_word(CMD_ADD, 8'h63, 32'h1234_5678);
        queue_word(CMD_ADD, 8'h40, 32'hFFFF_FFFF);
        queue_word(CMD_ADD, 8'h7F, 32'hFFFF_FFFF);
        queue_word(CMD_ADD, 8'h7F, 32'd1);
        queue_word(CMD_ADD, 8'h3F, 32'd7);
        queue_word(CMD_ADD, 8'h80, 32'd7);
        queue_word(CMD_ADD, 8'h00, 32'd7);
        queue_word(CMD_ADD, 8'hFF, 32'hFFFF_FFFF);
        queue_word(CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF);
        queue_word(CMD_ADD, 8'h47, 32'd3);
        queue_word(CMD_ADD, 8'h54, 32'd4);
        queue_word(CMD_ADD, 8'h41, 32'd9);
        queue_word(CMD_ADD, 8'h63, 32'd1);
        queue_word(CMD_CLEAR, 8'h00, 32'd0);
        wait_drained();

        // Writes to the unused index leave the mask alone.
        reg_write(ADDR_SPARE, {$urandom, $urandom});
        mask_readback();

        // Mask changes without a clear: only later adds use the new mask.
        reg_write(ADDR_MASK, '1);
        run_phase(110, 1'b1);

        reg_write(ADDR_MASK, {$urandom, $urandom});
        mask_readback();
        run_phase(110, 1'b1);

        reg_write(ADDR_MASK, '0);
        run_phase(60, 1'b0);

        reg_write(ADDR_MASK, 64'h8000_0000_0000_0001 | nucleotide_mask);
        mask_readback();
        run_phase(110, 1'b1);

        // Last stretch runs without idling on either side.
        reg_write(ADDR_MASK, '1);
        run_phase(90, 1'b0);

        // Let any stray result show up before the verdict.
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("dna_base_composition_counter_top regression: pass");
        else
            $display("dna_base_composition_counter_top regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/bcc_pkg.sv
rtl/core/bcc_cfg.sv
rtl/core/bcc_bin_store.sv
rtl/core/bcc_update.sv
rtl/core/dna_base_composition_counter_top.sv
sim/tb_dna_base_composition_counter_top.sv
